### hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

### hdl/far_pkg.sv
// ----------------------------------------------------------------------------
// far_pkg
// Constants and codes for the fraction arithmetic reducer.
// ----------------------------------------------------------------------------
`default_nettype none
package far_pkg;
    localparam int OPERAND_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
    localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;
endpackage
`default_nettype wire

### hdl/fraction_arithmetic_reducer.sv
// ----------------------------------------------------------------------------
// fraction_arithmetic_reducer
// Fraction add/sub/mul/div with gcd reduction by Euclid's algorithm.
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata: mode, num_a, den_a, num_b, den_b
// m_axis   out  tdata: res_num, res_den, status
//
// The products are formed in S_MUL and combined in S_SUM, then per Euclid
// step there is one pass of the shared restoring divider, then two divisions
// by the gcd. A zero denominator, or a zero num_b in div mode, goes straight
// to S_OUT with an error status. The result waits in the output register;
// the next item is taken once it is sent. Async reset clears control only.
`default_nettype none
`include "assert_macros.svh"
module fraction_arithmetic_reducer
    import far_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // mode, num_a, den_a, num_b, den_b from bit 0 up, zero padded
    input  wire logic [((4*OPERAND_WIDTH+2+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // res_num, res_den, status from bit 0 up, zero padded
    output logic [((4*OPERAND_WIDTH+2+7)/8)*8-1:0] m_axis_tdata
);
    localparam int OW = OPERAND_WIDTH;
    localparam int NW = 2 * OW + 1;
    localparam int DW = 2 * OW - 1;
    localparam int TW = ((4 * OW + 2 + 7) / 8) * 8;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SUM, S_GCD, S_DIVN, S_DIVD, S_OUT
    } state_t;

    state_t state_reg;
    logic [1:0]          mode_reg;
    logic signed [OW-1:0] na_reg, da_reg, nb_reg, db_reg;
    logic signed [NW-1:0] p1_reg, p2_reg, d_reg, n_reg;
    logic [NW-1:0]       x_reg, y_reg, un_reg, g_reg;
    logic signed [NW-1:0] rnum_reg;
    logic [DW-1:0]       rden_reg;
    logic [1:0]          status_reg;
    logic                neg_reg;
    logic                out_valid_reg;
    logic                div_start;
    logic [NW-1:0]       div_a, div_b;
    logic                div_busy, div_done;
    logic [NW-1:0]       div_q, div_r;

    logic [1:0]          in_mode;
    logic signed [OW-1:0] in_na, in_da, in_nb, in_db;
    assign in_mode = s_axis_tdata[1:0];
    assign in_na = s_axis_tdata[2+OW-1:2];
    assign in_da = s_axis_tdata[2+2*OW-1:2+OW];
    assign in_nb = s_axis_tdata[2+3*OW-1:2+2*OW];
    assign in_db = s_axis_tdata[2+4*OW-1:2+3*OW];

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;

    logic signed [OW-1:0]   m_a, m_b, m_c, m_d, m_e;
    logic signed [2*OW-1:0] prod_1, prod_2, prod_d;
    always_comb
    begin
        m_a = na_reg;
        m_b = db_reg;
        m_c = nb_reg;
        m_d = da_reg;
        m_e = db_reg;
        case (mode_t'(mode_reg))
            MODE_MUL: m_b = nb_reg;
            MODE_DIV: m_e = nb_reg;
            default: ;
        endcase
    end

    assign prod_1 = m_a * m_b;
    assign prod_2 = m_c * m_d;
    assign prod_d = m_d * m_e;

    function automatic logic [NW-1:0] mag(input logic signed [NW-1:0] v);
        mag = v[NW-1] ? NW'(-v) : NW'(v);
    endfunction

    always_comb
    begin
        div_start = 1'b0;
        div_a = x_reg;
        div_b = y_reg;
        case (state_reg)
            S_GCD:   div_start = !div_busy && !div_done && (y_reg != '0);
            S_DIVN:
            begin
                div_a = un_reg;
                div_b = g_reg;
                div_start = !div_busy && !div_done;
            end
            S_DIVD:
            begin
                div_a = mag(d_reg);
                div_b = g_reg;
                div_start = !div_busy && !div_done;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        mode_reg <= in_mode;
                        na_reg <= in_na;
                        da_reg <= in_da;
                        nb_reg <= in_nb;
                        db_reg <= in_db;
                        rnum_reg <= '0;
                        rden_reg <= '0;
                        if (in_da == '0 || in_db == '0)
                        begin
                            status_reg <= STATUS_ZERO_DEN;
                            state_reg  <= S_OUT;
                        end
                        else if (mode_t'(in_mode) == MODE_DIV && in_nb == '0)
                        begin
                            status_reg <= STATUS_DIV_ZERO;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            status_reg <= STATUS_OK;
                            state_reg  <= S_MUL;
                        end
                    end
                S_MUL:
                begin
                    p1_reg <= NW'(prod_1);
                    p2_reg <= NW'(prod_2);
                    d_reg  <= NW'(prod_d);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    case (mode_t'(mode_reg))
                        MODE_ADD: n_reg <= p1_reg + p2_reg;
                        MODE_SUB: n_reg <= p1_reg - p2_reg;
                        default:  n_reg <= p1_reg;
                    endcase
                    state_reg <= S_GCD;
                    y_reg <= mag(d_reg);
                    // numerator magnitude loaded into un_reg in the same cycle as n_reg
                    case (mode_t'(mode_reg))
                        MODE_ADD: un_reg <= mag(p1_reg + p2_reg);
                        MODE_SUB: un_reg <= mag(p1_reg - p2_reg);
                        default:  un_reg <= mag(p1_reg);
                    endcase
                    case (mode_t'(mode_reg))
                        MODE_ADD: x_reg <= mag(p1_reg + p2_reg);
                        MODE_SUB: x_reg <= mag(p1_reg - p2_reg);
                        default:  x_reg <= mag(p1_reg);
                    endcase
                end
                S_GCD:
                begin
                    if (div_done)
                    begin
                        x_reg <= y_reg;
                        y_reg <= div_r;
                    end
                    else if (!div_busy && y_reg == '0)
                    begin
                        g_reg <= (x_reg == '0) ? NW'(1) : x_reg;
                        neg_reg <= (un_reg != '0) && (n_reg[NW-1] != d_reg[NW-1]);
                        state_reg <= S_DIVN;
                    end
                end
                S_DIVN:
                    if (div_done)
                    begin
                        rnum_reg <= neg_reg ? NW'(-div_q) : div_q;
                        state_reg <= S_DIVD;
                    end
                S_DIVD:
                    if (div_done)
                    begin
                        rden_reg <= div_q[DW-1:0];
                        state_reg <= S_OUT;
                    end
                S_OUT:
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    far_divider #(.W(NW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(div_a), .divisor(div_b),
        .busy(div_busy), .done(div_done),
        .quotient(div_q), .remainder(div_r)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TW'({status_reg, rden_reg, rnum_reg});

    `ASSERT_IMPL(a_ready_idle, clk, rst_n, s_axis_tready |-> state_reg == S_IDLE)
    `ASSERT_IMPL(a_err_zero, clk, rst_n,
                 (out_valid_reg && status_reg != STATUS_OK) |-> rden_reg == '0)
    `ASSERT_IMPL(a_ok_den, clk, rst_n,
                 (out_valid_reg && status_reg == STATUS_OK) |-> rden_reg != '0)
endmodule
`default_nettype wire

### hdl/far_divider.sv
// ----------------------------------------------------------------------------
// far_divider
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module far_divider
    import far_pkg::*;
#(
    parameter int W = 2 * OPERAND_WIDTH_DEF + 1
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quot_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    assign shifted = {rem_reg, quot_reg[W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
                quot_reg <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                if (!trial[W])
                begin
                    rem_reg  <= trial[W-1:0];
                    quot_reg <= {quot_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= shifted[W-1:0];
                    quot_reg <= {quot_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

    `ASSERT_NEXT(a_done_ends_busy, clk, rst_n, busy_reg && cnt_reg == CW'(1) && !start,
                 done_reg && !busy_reg)
    `ASSERT_IMPL(a_done_not_busy, clk, rst_n, done_reg |-> !busy_reg)
    `ASSERT_IMPL(a_cnt_bound, clk, rst_n, busy_reg |-> cnt_reg != '0)
endmodule
`default_nettype wire
